// File: rtl/mlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types and constants for the module lifetime table.
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam int unsigned Entries  = 32;
  localparam int unsigned IdxW     = $clog2(Entries);
  localparam int unsigned CntW     = $clog2(Entries + 1);
  localparam int unsigned KeyW     = 384;
  localparam int unsigned RecW     = 32 * 3 + 1;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_UPDATE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture request
    logic scan_clr;  // reset scan state, start reading entry 0
    logic scan_step; // evaluate entry at scan index, read next
    logic commit;    // write chosen slot, build result
    logic rd_sel;    // read chosen slot
  } mlt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic is_none;
  } mlt_sts_t;

endpackage

// File: rtl/module_lifetime_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// module_lifetime_table
// Lifetime records for pluggable modules, keyed by vendor, part and serial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request beat: type,
//   six key words, current lifetime and timestamp. Output channel
//   (out_valid_o/out_ready_i) returns one result beat per request.
//   One request is handled at a time: a sequential scan reads every entry
//   of the key and record memories, one entry per cycle; the chosen slot
//   is then read and written before the result is offered, and the block
//   returns to idle once it is accepted. An unused request type skips the
//   scan and answers with all fields zero.
//   At reset the used and present bits clear at once; memory contents are
//   ignored until a slot is written, so no clearing pass is needed.
//   When the receiver stalls the result is held and no new request is
//   taken until it is accepted.
// ----------------------------------------------------------------------------
module module_lifetime_table import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [63:0] vendor_hi_i,
  input  logic [63:0] vendor_lo_i,
  input  logic [63:0] part_hi_i,
  input  logic [63:0] part_lo_i,
  input  logic [63:0] serial_hi_i,
  input  logic [63:0] serial_lo_i,
  input  logic [31:0] now_lifetime_i,
  input  logic [31:0] now_stamp_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [4:0]  slot_o,
  output logic        was_new_o,
  output logic        evicted_o,
  output logic [31:0] total_lifetime_o,
  output logic        present_after_o,
  output logic        warn_new_on_remove_o,
  output logic        warn_not_present_o
);
  mlt_cmd_t cmd;
  mlt_sts_t sts;

  mlt_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .cmd_o(cmd), .sts_i(sts)
  );

  mlt_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .req_type_i,
    .key_i({vendor_hi_i, vendor_lo_i, part_hi_i, part_lo_i,
            serial_hi_i, serial_lo_i}),
    .now_lifetime_i, .now_stamp_i,
    .slot_o, .was_new_o, .evicted_o, .total_lifetime_o, .present_after_o,
    .warn_new_on_remove_o, .warn_not_present_o
  );
endmodule

// File: rtl/mlt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module mlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// File: rtl/mlt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_datapath
// Request registers, entry scan, record memories and result assembly.
// ----------------------------------------------------------------------------
module mlt_datapath import mlt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  mlt_cmd_t    cmd_i,
  output mlt_sts_t    sts_o,
  input  logic [1:0]  req_type_i,
  input  logic [KeyW-1:0] key_i,
  input  logic [31:0] now_lifetime_i,
  input  logic [31:0] now_stamp_i,
  output logic [4:0]  slot_o,
  output logic        was_new_o,
  output logic        evicted_o,
  output logic [31:0] total_lifetime_o,
  output logic        present_after_o,
  output logic        warn_new_on_remove_o,
  output logic        warn_not_present_o
);
  logic [1:0]      req_q;
  logic [KeyW-1:0] key_q;
  logic [31:0]     life_q, stamp_q;
  logic [CntW-1:0] idx_q;
  logic            hit_q, empty_q;
  logic [IdxW-1:0] hit_idx_q, empty_idx_q, min_idx_q;
  logic [31:0]     min_stamp_q;
  logic [Entries-1:0] used_q, present_q;

  logic [IdxW-1:0] sel_idx, addr;
  logic            we;
  logic [KeyW-1:0] key_rd;
  logic [RecW-1:0] rec_rd, rec_wr;
  logic [31:0]     rd_life, rd_stamp, rd_mod;
  logic            rd_nz;
  logic [IdxW-1:0] cur_idx;

  assign cur_idx = idx_q[IdxW-1:0];
  // record: {lifetime, last stamp, last lifetime, nonzero key}
  assign rd_mod   = rec_rd[RecW-1 -: 32];
  assign rd_stamp = rec_rd[64:33];
  assign rd_life  = rec_rd[32:1];
  assign rd_nz    = rec_rd[0];

  assign sel_idx = hit_q ? hit_idx_q : (empty_q ? empty_idx_q : min_idx_q);
  always_comb begin
    if (cmd_i.rd_sel || cmd_i.commit) begin
      addr = sel_idx;
    end else if (cmd_i.scan_step) begin
      addr = cur_idx + IdxW'(1);
    end else begin
      addr = '0;
    end
  end
  assign we = cmd_i.commit;

  // next record values
  logic        is_new, pres_old, pres_new, w_np;
  logic [31:0] base_life, base_mod, mod_new;
  always_comb begin
    is_new    = !hit_q;
    pres_old  = present_q[sel_idx];
    base_life = is_new ? 32'd0 : rd_life;
    base_mod  = is_new ? 32'd0 : rd_mod;
    mod_new   = base_mod;
    pres_new  = pres_old;
    w_np      = 1'b0;
    case (req_e'(req_q))
      REQ_INSERT: pres_new = 1'b1;
      REQ_REMOVE: begin
        w_np     = !pres_old;
        mod_new  = base_mod + (life_q - base_life);
        pres_new = 1'b0;
      end
      default: begin
        if (!is_new && pres_old) begin
          mod_new = base_mod + (life_q - base_life);
        end
        pres_new = 1'b1;
      end
    endcase
    rec_wr = {mod_new, stamp_q, life_q, (key_q != '0)};
  end

  mlt_ram #(.Width(KeyW), .Depth(Entries)) u_key_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(key_q), .rdata_o(key_rd)
  );
  mlt_ram #(.Width(RecW), .Depth(Entries)) u_rec_ram (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(rec_wr), .rdata_o(rec_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q               <= '0;
      present_q            <= '0;
      req_q                <= '0;
      key_q                <= '0;
      life_q               <= '0;
      stamp_q              <= '0;
      idx_q                <= '0;
      hit_q                <= 1'b0;
      empty_q              <= 1'b0;
      hit_idx_q            <= '0;
      empty_idx_q          <= '0;
      min_idx_q            <= '0;
      min_stamp_q          <= '0;
      slot_o               <= '0;
      was_new_o            <= 1'b0;
      evicted_o            <= 1'b0;
      total_lifetime_o     <= '0;
      present_after_o      <= 1'b0;
      warn_new_on_remove_o <= 1'b0;
      warn_not_present_o   <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        req_q   <= req_type_i;
        key_q   <= key_i;
        life_q  <= now_lifetime_i;
        stamp_q <= now_stamp_i;
      end
      if (cmd_i.scan_clr) begin
        idx_q   <= '0;
        hit_q   <= 1'b0;
        empty_q <= 1'b0;
      end
      if (cmd_i.scan_step) begin
        idx_q <= idx_q + CntW'(1);
        if (!used_q[cur_idx]) begin
          if (!empty_q) begin
            empty_q     <= 1'b1;
            empty_idx_q <= cur_idx;
          end
        end else begin
          if (!hit_q && key_rd == key_q) begin
            hit_q     <= 1'b1;
            hit_idx_q <= cur_idx;
          end
        end
        // unused slots hold unknown stamps after reset; only matters when all used
        if (idx_q == '0 || rd_stamp < min_stamp_q) begin
          min_stamp_q <= rd_stamp;
          min_idx_q   <= cur_idx;
        end
      end
      if (cmd_i.commit) begin
        used_q[sel_idx]      <= 1'b1;
        present_q[sel_idx]   <= pres_new;
        slot_o               <= 5'(sel_idx);
        was_new_o            <= is_new;
        evicted_o            <= is_new && used_q[sel_idx] && rd_nz;
        total_lifetime_o     <= mod_new;
        present_after_o      <= pres_new;
        warn_new_on_remove_o <= (req_e'(req_q) == REQ_REMOVE) && is_new;
        warn_not_present_o   <= w_np;
      end
      if (cmd_i.load && req_e'(req_type_i) == REQ_NONE) begin
        slot_o               <= '0;
        was_new_o            <= 1'b0;
        evicted_o            <= 1'b0;
        total_lifetime_o     <= '0;
        present_after_o      <= 1'b0;
        warn_new_on_remove_o <= 1'b0;
        warn_not_present_o   <= 1'b0;
      end
    end
  end

  assign sts_o.scan_last = (idx_q == CntW'(Entries - 1));
  assign sts_o.is_none   = (req_e'(req_q) == REQ_NONE);
endmodule

// File: rtl/mlt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mlt_ctrl
// Sequencer for one request: scan, read chosen slot, commit, hand off (unused type: straight to hand off).
// ----------------------------------------------------------------------------
module mlt_ctrl import mlt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mlt_cmd_t cmd_o,
  input  mlt_sts_t sts_i
);
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_START = 6'b000010,
    ST_SCAN  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_WRITE = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        cmd_o.scan_clr = 1'b1;
        state_d = sts_i.is_none ? ST_OUT : ST_SCAN;
      end
      ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_sel = 1'b1;
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.commit = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule
